FILE: hdl/desa_pkg.sv
// Shared constants, codes and helper functions for the double-ended stack allocator.
// No dependencies; the other files of the block, all but desa_hdr_ram, refer to this package by scoped names.
`default_nettype none

package desa_pkg;

    // Region and header geometry.
    localparam int REGION_BYTES = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int HDR_DEPTH    = (REGION_BYTES + HEADER_BYTES - 1) / HEADER_BYTES;
    localparam int HDR_AW       = $clog2(HDR_DEPTH);
    localparam int HB_W         = $clog2(HEADER_BYTES);

    // Field widths.
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 13;
    localparam int HDR_W      = 13;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MIN_SIZE   = 16;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0] BASE_RESET = '0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PULL_FRONT       = 3'd0;
    localparam logic [OP_W-1:0] OP_PULL_BACK        = 3'd1;
    localparam logic [OP_W-1:0] OP_PULL_FRONT_NOPOP = 3'd2;
    localparam logic [OP_W-1:0] OP_PULL_BACK_NOPOP  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_FRONT        = 3'd4;
    localparam logic [OP_W-1:0] OP_POP_BACK         = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COLLIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 2'd1;

    // Effective region size, clamped to the supported range.
    function automatic logic [ADDR_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
        logic [ADDR_W-1:0] s;
        s = ADDR_W'(size);
        if (s < ADDR_W'(MIN_SIZE)) begin
            s = ADDR_W'(MIN_SIZE);
        end
        if (s > ADDR_W'(REGION_BYTES)) begin
            s = ADDR_W'(REGION_BYTES);
        end
        return s;
    endfunction

    // Last byte of the region.
    function automatic logic [ADDR_W-1:0] tail_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [SIZE_W-1:0] size);
        return base + eff_size(size) - ADDR_W'(1);
    endfunction

    // Header store entry that belongs to an absolute address.
    function automatic logic [HDR_AW-1:0] hdr_index(input logic [ADDR_W-1:0] addr,
                                                    input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] diff;
        diff = addr - base;
        return diff[HB_W +: HDR_AW];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/desa_if.sv
// Handshake interfaces for the request and response channels of the allocator.
// Depends on desa_pkg for the field widths.
`default_nettype none

interface desa_req_if;
    logic                               valid;
    logic                               ready;
    logic [desa_pkg::OP_W-1:0]          operation;
    logic [desa_pkg::SIZE_W-1:0]        request_size;
    logic                               marker_present;
    logic [desa_pkg::ADDR_W-1:0]        marker_address;

    modport source (output valid, operation, request_size, marker_present, marker_address,
                    input ready);
    modport sink   (input valid, operation, request_size, marker_present, marker_address,
                    output ready);
endinterface

interface desa_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [desa_pkg::ADDR_W-1:0]        granted_address;
    logic [desa_pkg::STATUS_W-1:0]      status;

    modport source (output valid, granted_address, status, input ready);
    modport sink   (input valid, granted_address, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/desa_hdr_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the header words of the allocator; no dependencies.
`default_nettype none

module desa_hdr_ram #(
    parameter int DATA_W = 13,
    parameter int ADDR_W = 9,
    parameter int DEPTH  = 512
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/desa_ctrl.sv
// Pointer registers, configuration and the two-state sequencer of the allocator.
// Depends on desa_pkg and desa_if; drives the header RAM ports.
`default_nettype none

module desa_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    desa_req_if.sink                                 req,
    desa_rsp_if.source                               rsp,
    input  wire logic                                cfg_we,
    input  wire logic [desa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [desa_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     ram_wr_en,
    output logic      [desa_pkg::HDR_AW-1:0]         ram_wr_addr,
    output logic      [desa_pkg::HDR_W-1:0]          ram_wr_data,
    output logic                                     ram_rd_en,
    output logic      [desa_pkg::HDR_AW-1:0]         ram_rd_addr,
    input  wire logic [desa_pkg::HDR_W-1:0]          ram_rd_data
);

    localparam int AW  = desa_pkg::ADDR_W;
    localparam int HBW = desa_pkg::HB_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                          state_reg,   state_next;
    logic [AW-1:0]                   front_reg,   front_next;
    logic [AW-1:0]                   back_reg,    back_next;
    logic [AW-1:0]                   base_reg,    base_next;
    logic [desa_pkg::SIZE_W-1:0]     size_reg,    size_next;
    logic                            out_valid_reg, out_valid_next;
    logic [AW-1:0]                   grant_reg,   grant_next;
    logic [desa_pkg::STATUS_W-1:0]   status_reg,  status_next;

    // Captured transaction payload.
    logic [desa_pkg::OP_W-1:0]       op_reg;
    logic [desa_pkg::SIZE_W-1:0]     size_req_reg;
    logic                            marker_reg;
    logic [AW-1:0]                   maddr_reg;

    logic                            in_fire;
    logic                            slot_free;

    // Datapath terms of the pull operations.
    logic [AW:0]                     front_sum;
    logic [HBW-1:0]                  front_adj;
    logic [AW+1:0]                   front_hdr;
    logic [AW+1:0]                   front_new;
    logic [AW+1:0]                   back_start;
    logic [AW+1:0]                   back_t;
    logic [AW+1:0]                   back_new;
    logic [AW+1:0]                   front_ext;
    logic [AW-1:0]                   tail_now;

    assign in_fire   = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid           = out_valid_reg;
    assign rsp.granted_address = grant_reg;
    assign rsp.status          = status_reg;

    assign tail_now = desa_pkg::tail_addr(base_reg, size_reg);

    // Front pull: end of request, padding to the header boundary, header slot, new pointer.
    assign front_sum = {1'b0, front_reg} + (AW+1)'(size_req_reg);
    assign front_adj = HBW'(0) - front_sum[HBW-1:0];
    assign front_hdr = {1'b0, front_sum} + (AW+2)'(front_adj);
    assign front_new = front_hdr + (AW+2)'(desa_pkg::HEADER_BYTES);
    assign front_ext = {2'b00, front_reg};

    // Back pull: start of block, header slot below it aligned down.
    assign back_start = {2'b00, back_reg} - (AW+2)'(size_req_reg);
    assign back_t     = back_start - (AW+2)'(desa_pkg::HEADER_BYTES);
    assign back_new   = {back_t[AW+1:HBW], {HBW{1'b0}}};

    // Header read is issued with the accepted transaction, from the current pointers.
    assign ram_rd_en   = in_fire;
    assign ram_rd_addr = (req.operation == desa_pkg::OP_POP_FRONT)
                       ? desa_pkg::hdr_index(front_reg - AW'(desa_pkg::HEADER_BYTES), base_reg)
                       : desa_pkg::hdr_index(back_reg, base_reg);

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        base_next      = base_reg;
        size_next      = size_reg;
        out_valid_next = out_valid_reg;
        grant_next     = grant_reg;
        status_next    = status_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = desa_pkg::hdr_index(front_hdr[AW-1:0], base_reg);
        ram_wr_data    = desa_pkg::HDR_W'(size_req_reg + desa_pkg::SIZE_W'(front_adj));

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    grant_next     = '0;
                    status_next    = desa_pkg::ST_OK;
                    case (op_reg)
                        desa_pkg::OP_PULL_FRONT:
                        begin
                            if (front_new < {2'b00, back_reg})
                            begin
                                ram_wr_en  = 1'b1;
                                grant_next = front_reg;
                                front_next = front_new[AW-1:0];
                            end
                            else
                            begin
                                status_next = desa_pkg::ST_COLLIDE;
                            end
                        end
                        desa_pkg::OP_PULL_BACK:
                        begin
                            ram_wr_addr = desa_pkg::hdr_index(back_new[AW-1:0], base_reg);
                            ram_wr_data = desa_pkg::HDR_W'(size_req_reg
                                          + desa_pkg::SIZE_W'(back_t[HBW-1:0]));
                            if ($signed(front_ext) < $signed(back_new))
                            begin
                                ram_wr_en  = 1'b1;
                                grant_next = back_start[AW-1:0];
                                back_next  = back_new[AW-1:0];
                            end
                            else
                            begin
                                status_next = desa_pkg::ST_COLLIDE;
                            end
                        end
                        desa_pkg::OP_PULL_FRONT_NOPOP:
                        begin
                            if (front_sum < {1'b0, back_reg})
                            begin
                                grant_next = front_reg;
                                front_next = front_sum[AW-1:0];
                            end
                            else
                            begin
                                status_next = desa_pkg::ST_COLLIDE;
                            end
                        end
                        desa_pkg::OP_PULL_BACK_NOPOP:
                        begin
                            if ($signed(front_ext) < $signed(back_start))
                            begin
                                grant_next = back_start[AW-1:0];
                                back_next  = back_start[AW-1:0];
                            end
                            else
                            begin
                                status_next = desa_pkg::ST_COLLIDE;
                            end
                        end
                        desa_pkg::OP_POP_FRONT:
                        begin
                            if (marker_reg)
                            begin
                                front_next = maddr_reg;
                            end
                            else if (front_reg == base_reg)
                            begin
                                status_next = desa_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                front_next = front_reg - AW'(desa_pkg::HEADER_BYTES)
                                           - AW'(ram_rd_data);
                            end
                        end
                        desa_pkg::OP_POP_BACK:
                        begin
                            if (marker_reg)
                            begin
                                back_next = maddr_reg;
                            end
                            else if (back_reg == tail_now)
                            begin
                                status_next = desa_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                back_next = back_reg + AW'(ram_rd_data)
                                          + AW'(desa_pkg::HEADER_BYTES);
                            end
                        end
                        default:
                        begin
                            // Unused codes leave everything unchanged.
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A configuration write to the base or size register reinitializes both pointers.
        if (cfg_we)
        begin
            case (cfg_index)
                desa_pkg::CFG_REGION_BASE:
                begin
                    base_next  = cfg_data[AW-1:0];
                    front_next = cfg_data[AW-1:0];
                    back_next  = desa_pkg::tail_addr(cfg_data[AW-1:0], size_reg);
                end
                desa_pkg::CFG_REGION_SIZE:
                begin
                    size_next  = cfg_data[desa_pkg::SIZE_W-1:0];
                    front_next = base_reg;
                    back_next  = desa_pkg::tail_addr(base_reg,
                                                     cfg_data[desa_pkg::SIZE_W-1:0]);
                end
                default:
                begin
                    // Writes beyond the register list are ignored.
                end
            endcase
        end
    end

    // State, pointers, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= desa_pkg::BASE_RESET;
            size_reg      <= desa_pkg::SIZE_RESET;
            front_reg     <= desa_pkg::BASE_RESET;
            back_reg      <= desa_pkg::tail_addr(desa_pkg::BASE_RESET, desa_pkg::SIZE_RESET);
            out_valid_reg <= 1'b0;
            grant_reg     <= '0;
            status_reg    <= desa_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            size_reg      <= size_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            out_valid_reg <= out_valid_next;
            grant_reg     <= grant_next;
            status_reg    <= status_next;
        end
    end

    // Payload capture of the accepted transaction.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg       <= req.operation;
            size_req_reg <= req.request_size;
            marker_reg   <= req.marker_present;
            maddr_reg    <= req.marker_address;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/double_ended_stack_allocator.sv
// Top level of the double-ended stack allocator: sequencer plus header memory.
// Depends on desa_pkg, desa_if, desa_hdr_ram and desa_ctrl.
//
//   Channel   Direction  Handshake            Contents
//   req       in         valid/ready          operation, request_size, marker fields
//   rsp       out        valid/ready          granted_address, status
//   cfg       in         cfg_we (no stall)    cfg_index, cfg_data
//
// The accept in the idle state issues the header read; the execute state then uses the
// registered header RAM read data and updates the pointers. A new request is taken
// only once the last one has left the execute state; the output register lets the next
// request be accepted while a response waits. A stalled response holds the block in its
// execute state. Reset clears pointers to the default region; the header RAM is not
// cleared and needs no clearing pass.
`default_nettype none

module double_ended_stack_allocator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    desa_req_if.sink                             req,
    desa_rsp_if.source                           rsp,
    input  wire logic                            cfg_we,
    input  wire logic [desa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [desa_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                          ram_wr_en;
    logic [desa_pkg::HDR_AW-1:0]   ram_wr_addr;
    logic [desa_pkg::HDR_W-1:0]    ram_wr_data;
    logic                          ram_rd_en;
    logic [desa_pkg::HDR_AW-1:0]   ram_rd_addr;
    logic [desa_pkg::HDR_W-1:0]    ram_rd_data;

    // Sequencer and pointer state.
    desa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Header word store.
    desa_hdr_ram #(
        .DATA_W (desa_pkg::HDR_W),
        .ADDR_W (desa_pkg::HDR_AW),
        .DEPTH  (desa_pkg::HDR_DEPTH)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

FILE: hdl/desa_checker.sv
// Port-level checker for the double-ended stack allocator and its bind statement.
// Depends on desa_pkg for codes and widths.
`default_nettype none

module desa_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           req_valid,
    input wire logic                           req_ready,
    input wire logic                           rsp_valid,
    input wire logic                           rsp_ready,
    input wire logic [desa_pkg::ADDR_W-1:0]    rsp_granted_address,
    input wire logic [desa_pkg::STATUS_W-1:0]  rsp_status
);

    // Status is always one of the defined codes.
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == desa_pkg::ST_OK || rsp_status == desa_pkg::ST_COLLIDE
                       || rsp_status == desa_pkg::ST_EMPTY))
        else $error("illegal status code");

    // A failed transaction grants no address.
    a_error_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != desa_pkg::ST_OK) |-> (rsp_granted_address == '0))
        else $error("error response carries an address");

    // Two requests are never taken in consecutive cycles.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted during execute cycle");

    // A fresh response follows an accepted request.
    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without matching request");

    // A stalled response holds its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_granted_address) && $stable(rsp_status)))
        else $error("stalled response changed");

endmodule

bind double_ended_stack_allocator desa_checker u_desa_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_granted_address (rsp.granted_address),
    .rsp_status          (rsp.status)
);

`default_nettype wire
